[hdl/tksp_pkg.sv]
// ---------------------------------------------------------------------------
// tksp_pkg: terminal key sequence parser shared definitions
// Byte codes, key kinds, parser modes and the CSI helper types.
// ---------------------------------------------------------------------------
package tksp_pkg;

   localparam int MAX_PARAMS  = 8;
   localparam int MAX_SEQ_LEN = 64;
   localparam int PCNT_W      = $clog2(MAX_PARAMS + 1);
   localparam int PIDX_W      = $clog2(MAX_PARAMS);
   localparam int SEQ_W       = $clog2(MAX_SEQ_LEN + 1);

   // received byte codes
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_ERASE     = 8'h7F;
   localparam logic [7:0] CH_CSI_OPEN  = 8'h5B;   // '['
   localparam logic [7:0] CH_SS3_OPEN  = 8'h4F;   // 'O'
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;
   localparam logic [7:0] INTER_LO     = 8'h20;
   localparam logic [7:0] INTER_HI     = 8'h2F;
   localparam logic [7:0] PARAM_LO     = 8'h30;
   localparam logic [7:0] PARAM_HI     = 8'h3F;
   localparam logic [7:0] FINAL_HI     = 8'h7E;
   localparam logic [7:0] KEYPAD_SHIFT = 8'h40;   // 'j'..'y' -> '*'..'9'

   // key kinds
   localparam logic [4:0] KIND_INCOMPLETE = 5'd0;
   localparam logic [4:0] KIND_PLAIN      = 5'd1;
   localparam logic [4:0] KIND_UNKNOWN    = 5'd2;
   localparam logic [4:0] KIND_ESCBYTE    = 5'd3;
   localparam logic [4:0] KIND_BS         = 5'd4;
   localparam logic [4:0] KIND_UP         = 5'd5;
   localparam logic [4:0] KIND_DOWN       = 5'd6;
   localparam logic [4:0] KIND_RIGHT      = 5'd7;
   localparam logic [4:0] KIND_LEFT       = 5'd8;
   localparam logic [4:0] KIND_HOME       = 5'd9;
   localparam logic [4:0] KIND_END        = 5'd10;
   localparam logic [4:0] KIND_PGUP       = 5'd11;
   localparam logic [4:0] KIND_PGDN       = 5'd12;
   localparam logic [4:0] KIND_INS        = 5'd13;
   localparam logic [4:0] KIND_DEL        = 5'd14;
   localparam logic [4:0] KIND_STAB       = 5'd15;
   localparam logic [4:0] KIND_ENTER      = 5'd16;
   localparam logic [4:0] KIND_F1         = 5'd17;
   localparam logic [4:0] KIND_F2         = 5'd18;
   localparam logic [4:0] KIND_F3         = 5'd19;
   localparam logic [4:0] KIND_F4         = 5'd20;
   localparam logic [4:0] KIND_F5         = 5'd21;
   localparam logic [4:0] KIND_F6         = 5'd22;
   localparam logic [4:0] KIND_F7         = 5'd23;
   localparam logic [4:0] KIND_F8         = 5'd24;
   localparam logic [4:0] KIND_F9         = 5'd25;
   localparam logic [4:0] KIND_F10        = 5'd26;
   localparam logic [4:0] KIND_F11        = 5'd27;
   localparam logic [4:0] KIND_F12        = 5'd28;
   localparam logic [4:0] KIND_MPRESS     = 5'd29;
   localparam logic [4:0] KIND_MRELEASE   = 5'd30;

   localparam logic [2:0] BTN_WHEEL_UP    = 3'd4;
   localparam logic [2:0] BTN_WHEEL_DOWN  = 3'd5;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_APP    = 2'd2,
      MODE_CSI    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PFX_NONE  = 2'd0,
      PFX_LT    = 2'd1,
      PFX_OTHER = 2'd2
   } prefix_type;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [2:0]  button;
      logic        released;
      logic        moving;
      logic [2:0]  modifiers;
   } mouse_rec_type;

   typedef struct packed {
      logic [4:0]    key_kind;
      logic [7:0]    byte_value;
      mouse_rec_type mouse;
   } result_type;

   // parameter file control from the parser
   typedef struct packed {
      logic              clear;
      logic              digit_we;
      logic [PIDX_W-1:0] idx;
      logic [3:0]        digit;
   } param_ctl_type;

   function automatic logic [4:0] tilde_key(input logic [15:0] p);
      logic [4:0] k;
      case (p)
         16'd1, 16'd7:  k = KIND_HOME;
         16'd2:         k = KIND_INS;
         16'd3:         k = KIND_DEL;
         16'd4, 16'd8:  k = KIND_END;
         16'd5:         k = KIND_PGUP;
         16'd6:         k = KIND_PGDN;
         16'd11:        k = KIND_F1;
         16'd12:        k = KIND_F2;
         16'd13:        k = KIND_F3;
         16'd14:        k = KIND_F4;
         16'd15:        k = KIND_F5;
         16'd17:        k = KIND_F6;
         16'd18:        k = KIND_F7;
         16'd19:        k = KIND_F8;
         16'd20:        k = KIND_F9;
         16'd21:        k = KIND_F10;
         16'd23:        k = KIND_F11;
         16'd24:        k = KIND_F12;
         default:       k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

[hdl/tksp_param_file.sv]
// ---------------------------------------------------------------------------
// tksp_param_file: CSI parameter registers
// Holds the decimal CSI parameters and accumulates digits with saturation.
// ---------------------------------------------------------------------------
module tksp_param_file (
   input  logic                  clock,
   input  logic                  reset,
   input  tksp_pkg::param_ctl_type ctl,
   output logic [15:0]           p0,
   output logic [15:0]           p1,
   output logic [15:0]           p2
);

   logic [15:0] vals_ff [tksp_pkg::MAX_PARAMS];
   logic [15:0] cur;
   logic [19:0] acc;
   logic [15:0] sat;

   // value*10 + digit, as two shifted adds
   always_comb begin
      cur = vals_ff[ctl.idx];
      acc = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {16'h0000, ctl.digit};
      sat = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < tksp_pkg::MAX_PARAMS; i++) vals_ff[i] <= 16'h0000;
      end else if (ctl.digit_we) begin
         vals_ff[ctl.idx] <= sat;
      end
   end

   assign p0 = vals_ff[0];
   assign p1 = vals_ff[1];
   assign p2 = vals_ff[2];

endmodule

[hdl/tksp_decoder.sv]
// ---------------------------------------------------------------------------
// tksp_decoder: escape sequence state machine
// Per-byte mode tracking, CSI bookkeeping, key decode and mouse record.
// ---------------------------------------------------------------------------
module tksp_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              byte_c,
   input  logic [15:0]             p0,
   input  logic [15:0]             p1,
   input  logic [15:0]             p2,
   output tksp_pkg::param_ctl_type pctl,
   output tksp_pkg::result_type    result
);

   tksp_pkg::mode_type             mode_ff, mode_in;
   tksp_pkg::prefix_type           pfx_ff, pfx_in;
   logic [tksp_pkg::SEQ_W-1:0]     seqlen_ff, seqlen_in;
   logic [tksp_pkg::PCNT_W-1:0]    pcnt_ff, pcnt_in;
   logic                           dseen_ff, dseen_in;
   logic                           iseen_ff, iseen_in;
   tksp_pkg::mouse_rec_type        rec_ff, rec_in;

   logic [4:0]  kind;
   logic [7:0]  bv;
   logic [15:0] col_raw, row_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= tksp_pkg::MODE_NORMAL;
         pfx_ff    <= tksp_pkg::PFX_NONE;
         seqlen_ff <= '0;
         pcnt_ff   <= '0;
         dseen_ff  <= 1'b0;
         iseen_ff  <= 1'b0;
         rec_ff    <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         pfx_ff    <= pfx_in;
         seqlen_ff <= seqlen_in;
         pcnt_ff   <= pcnt_in;
         dseen_ff  <= dseen_in;
         iseen_ff  <= iseen_in;
         rec_ff    <= rec_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pfx_in    = pfx_ff;
      seqlen_in = seqlen_ff;
      pcnt_in   = pcnt_ff;
      dseen_in  = dseen_ff;
      iseen_in  = iseen_ff;
      rec_in    = rec_ff;
      kind      = tksp_pkg::KIND_INCOMPLETE;
      bv        = 8'h00;
      pctl      = '0;
      col_raw   = (pcnt_ff > tksp_pkg::PCNT_W'(1)) ? p1 : 16'h0000;
      row_raw   = (pcnt_ff > tksp_pkg::PCNT_W'(2)) ? p2 : 16'h0000;

      case (mode_ff)
         tksp_pkg::MODE_NORMAL: begin
            if (byte_c == tksp_pkg::CH_ESC) begin
               mode_in = tksp_pkg::MODE_ESC;
            end else if (byte_c == tksp_pkg::CH_BS || byte_c == tksp_pkg::CH_ERASE) begin
               kind = tksp_pkg::KIND_BS;
            end else begin
               kind = tksp_pkg::KIND_PLAIN;
               bv   = byte_c;
            end
         end
         tksp_pkg::MODE_ESC: begin
            if (byte_c == tksp_pkg::CH_CSI_OPEN) begin
               mode_in    = tksp_pkg::MODE_CSI;
               pfx_in     = tksp_pkg::PFX_NONE;
               seqlen_in  = '0;
               pcnt_in    = '0;
               dseen_in   = 1'b0;
               iseen_in   = 1'b0;
               pctl.clear = 1'b1;
            end else if (byte_c == tksp_pkg::CH_SS3_OPEN) begin
               mode_in = tksp_pkg::MODE_APP;
            end else begin
               mode_in = tksp_pkg::MODE_NORMAL;
               kind    = tksp_pkg::KIND_ESCBYTE;
               bv      = byte_c;
            end
         end
         tksp_pkg::MODE_APP: begin
            mode_in = tksp_pkg::MODE_NORMAL;
            kind    = tksp_pkg::KIND_UNKNOWN;
            if (byte_c == "A") kind = tksp_pkg::KIND_UP;
            else if (byte_c == "B") kind = tksp_pkg::KIND_DOWN;
            else if (byte_c == "C") kind = tksp_pkg::KIND_RIGHT;
            else if (byte_c == "D") kind = tksp_pkg::KIND_LEFT;
            else if (byte_c == "P") kind = tksp_pkg::KIND_F1;
            else if (byte_c == "Q") kind = tksp_pkg::KIND_F2;
            else if (byte_c == "R") kind = tksp_pkg::KIND_F3;
            else if (byte_c == "S") kind = tksp_pkg::KIND_F4;
            else if (byte_c >= "j" && byte_c <= "y" && byte_c != "w") begin
               // keypad: 'j'..'o' give "*+,-./", 'p'..'y' other than 'w' give digits
               kind = tksp_pkg::KIND_PLAIN;
               bv   = byte_c - tksp_pkg::KEYPAD_SHIFT;
            end
            else if (byte_c == "H") kind = tksp_pkg::KIND_HOME;
            else if (byte_c == "F") kind = tksp_pkg::KIND_END;
            else if (byte_c == "G") kind = tksp_pkg::KIND_PGDN;
            else if (byte_c == "I") kind = tksp_pkg::KIND_PGUP;
            else if (byte_c == "L") kind = tksp_pkg::KIND_INS;
            else if (byte_c == "w") kind = tksp_pkg::KIND_DEL;
            else if (byte_c == "M") kind = tksp_pkg::KIND_ENTER;
            else if (byte_c == "X") begin
               kind = tksp_pkg::KIND_PLAIN;
               bv   = "=";
            end
         end
         tksp_pkg::MODE_CSI: begin
            if (byte_c == tksp_pkg::CH_ESC) begin
               mode_in = tksp_pkg::MODE_ESC;
            end else if (seqlen_ff >= tksp_pkg::SEQ_W'(tksp_pkg::MAX_SEQ_LEN)) begin
               mode_in = tksp_pkg::MODE_NORMAL;
               kind    = tksp_pkg::KIND_UNKNOWN;
            end else begin
               seqlen_in = seqlen_ff + 1'b1;
               if (byte_c < tksp_pkg::CTRL_LIMIT || byte_c == tksp_pkg::CH_ERASE) begin
                  mode_in = tksp_pkg::MODE_NORMAL;
                  if (byte_c == tksp_pkg::CH_BS || byte_c == tksp_pkg::CH_ERASE) begin
                     kind = tksp_pkg::KIND_BS;
                  end else begin
                     kind = tksp_pkg::KIND_PLAIN;
                     bv   = byte_c;
                  end
               end else if (byte_c > tksp_pkg::FINAL_HI) begin
                  mode_in = tksp_pkg::MODE_NORMAL;
                  kind    = tksp_pkg::KIND_UNKNOWN;
               end else if (byte_c >= tksp_pkg::PARAM_LO && byte_c <= tksp_pkg::PARAM_HI) begin
                  if (iseen_ff) begin
                     // parameter bytes after an intermediate are dropped
                  end else if (seqlen_ff == '0 && (byte_c == "<" || byte_c == "?" ||
                                                   byte_c == "=" || byte_c == ">")) begin
                     pfx_in = (byte_c == "<") ? tksp_pkg::PFX_LT : tksp_pkg::PFX_OTHER;
                  end else if (byte_c == ";" || byte_c == ":") begin
                     if (pcnt_ff < tksp_pkg::PCNT_W'(tksp_pkg::MAX_PARAMS)) begin
                        pcnt_in = pcnt_ff + 1'b1;
                     end
                     dseen_in = 1'b0;
                  end else if (byte_c <= "9") begin
                     if (!dseen_ff && pcnt_ff == '0) pcnt_in = tksp_pkg::PCNT_W'(1);
                     dseen_in      = 1'b1;
                     pctl.digit_we = 1'b1;
                     pctl.idx      = tksp_pkg::PIDX_W'(pcnt_in - 1'b1);
                     pctl.digit    = byte_c[3:0];
                  end
               end else if (byte_c >= tksp_pkg::INTER_LO && byte_c <= tksp_pkg::INTER_HI) begin
                  iseen_in = 1'b1;
               end else begin
                  // final byte
                  mode_in = tksp_pkg::MODE_NORMAL;
                  if (pfx_ff == tksp_pkg::PFX_LT && (byte_c == "M" || byte_c == "m")) begin
                     rec_in.col        = (col_raw != 16'h0000) ? col_raw - 1'b1 : 16'h0000;
                     rec_in.row        = (row_raw != 16'h0000) ? row_raw - 1'b1 : 16'h0000;
                     rec_in.released   = (byte_c == "m");
                     rec_in.moving     = p0[5];
                     rec_in.modifiers  = p0[4:2];
                     if (p0[6]) begin
                        rec_in.button = p0[0] ? tksp_pkg::BTN_WHEEL_DOWN
                                              : tksp_pkg::BTN_WHEEL_UP;
                     end else begin
                        rec_in.button = {1'b0, p0[1:0]};
                     end
                     kind = (byte_c == "m") ? tksp_pkg::KIND_MRELEASE
                                            : tksp_pkg::KIND_MPRESS;
                  end else if (pfx_ff != tksp_pkg::PFX_NONE) begin
                     kind = tksp_pkg::KIND_UNKNOWN;
                  end else begin
                     case (byte_c)
                        "A":     kind = tksp_pkg::KIND_UP;
                        "B":     kind = tksp_pkg::KIND_DOWN;
                        "C":     kind = tksp_pkg::KIND_RIGHT;
                        "D":     kind = tksp_pkg::KIND_LEFT;
                        "H":     kind = tksp_pkg::KIND_HOME;
                        "F":     kind = tksp_pkg::KIND_END;
                        "G":     kind = tksp_pkg::KIND_PGDN;
                        "I":     kind = tksp_pkg::KIND_PGUP;
                        "L":     kind = tksp_pkg::KIND_INS;
                        "Z":     kind = tksp_pkg::KIND_STAB;
                        "~":     kind = tksp_pkg::tilde_key(p0);
                        default: kind = tksp_pkg::KIND_UNKNOWN;
                     endcase
                  end
               end
            end
         end
         default: begin
            mode_in = tksp_pkg::MODE_NORMAL;
         end
      endcase

      result.key_kind   = kind;
      result.byte_value = bv;
      result.mouse      = rec_in;
   end

`ifndef SYNTH
   a_pcnt_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= tksp_pkg::PCNT_W'(tksp_pkg::MAX_PARAMS))
      else $error("parameter count beyond limit");

   a_seqlen_bound: assert property (@(posedge clock) disable iff (reset)
      seqlen_ff <= tksp_pkg::SEQ_W'(tksp_pkg::MAX_SEQ_LEN))
      else $error("sequence length beyond limit");

   a_csi_entry: assert property (@(posedge clock) disable iff (reset)
      (fire && mode_ff == tksp_pkg::MODE_ESC && byte_c == tksp_pkg::CH_CSI_OPEN)
      |=> (mode_ff == tksp_pkg::MODE_CSI && seqlen_ff == '0 && pcnt_ff == '0 && !iseen_ff))
      else $error("CSI entry did not clear bookkeeping");

   a_rec_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(rec_ff))
      else $error("mouse record changed without a transfer");

   a_digit_only_csi: assert property (@(posedge clock) disable iff (reset)
      pctl.digit_we |-> (mode_ff == tksp_pkg::MODE_CSI && pcnt_in != '0))
      else $error("digit write outside a CSI parameter");
`endif

endmodule

[hdl/terminal_key_sequence_parser_top.sv]
// ---------------------------------------------------------------------------
// terminal_key_sequence_parser_top: terminal key escape sequence decoder
// Decodes a stream of received terminal bytes into key and mouse events.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer (req_valid / req_stall).
//   rsp_* returns exactly one result per input byte, in order: the key
//   kind, the byte value for plain and ESC+byte kinds, and the current
//   mouse record (updated by SGR mouse finals).
//   A byte accepted into the input register is decoded into the result
//   register, which drives rsp_* (one input register, one result register).
//   Throughput: one byte per cycle while rsp_stall is low; the per-byte
//   parser update is a single pass of logic between the two registers.
//   When rsp_stall is high with a result waiting, the result holds, the
//   input register keeps its byte and req_stall rises once it is full.
//   Reset (synchronous, active high) empties both registers, returns the
//   parser to normal mode and zeroes the CSI parameters and mouse record.
// ---------------------------------------------------------------------------
module terminal_key_sequence_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_key_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_mouse_col,
   output logic [15:0] rsp_mouse_row,
   output logic [2:0]  rsp_mouse_button,
   output logic        rsp_mouse_is_release,
   output logic        rsp_mouse_is_motion,
   output logic [2:0]  rsp_mouse_modifiers
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    out_valid_ff, out_valid_in;
   tksp_pkg::result_type    out_data_ff;
   tksp_pkg::result_type    result;
   tksp_pkg::param_ctl_type pctl;
   logic [15:0]             p0, p1, p2;
   logic                    advance;
   logic                    req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_byte_in;
      if (advance) out_data_ff <= result;
   end

   tksp_param_file u_params (
      .clock (clock),
      .reset (reset),
      .ctl   (advance ? pctl : tksp_pkg::param_ctl_type'('0)),
      .p0    (p0),
      .p1    (p1),
      .p2    (p2)
   );

   tksp_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .byte_c (in_byte_ff),
      .p0     (p0),
      .p1     (p1),
      .p2     (p2),
      .pctl   (pctl),
      .result (result)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_key_kind         = out_data_ff.key_kind;
   assign rsp_byte_value       = out_data_ff.byte_value;
   assign rsp_mouse_col        = out_data_ff.mouse.col;
   assign rsp_mouse_row        = out_data_ff.mouse.row;
   assign rsp_mouse_button     = out_data_ff.mouse.button;
   assign rsp_mouse_is_release = out_data_ff.mouse.released;
   assign rsp_mouse_is_motion  = out_data_ff.mouse.moving;
   assign rsp_mouse_modifiers  = out_data_ff.mouse.modifiers;

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: terminal key sequence parser checker
// Streams received terminal bytes into the parser, from a directed opener and
// then random key, keypad, CSI and SGR mouse sequences mixed with noise and
// broken sequences. A local decoder predicts every result; the monitor checks
// the results in order. Both sides idle at random between transfers.
// ---------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_BYTES = 2000;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_key_kind;
   logic [7:0]  rsp_byte_value;
   logic [15:0] rsp_mouse_col;
   logic [15:0] rsp_mouse_row;
   logic [2:0]  rsp_mouse_button;
   logic        rsp_mouse_is_release;
   logic        rsp_mouse_is_motion;
   logic [2:0]  rsp_mouse_modifiers;

   terminal_key_sequence_parser_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_key_kind(rsp_key_kind),
      .rsp_byte_value(rsp_byte_value),
      .rsp_mouse_col(rsp_mouse_col),
      .rsp_mouse_row(rsp_mouse_row),
      .rsp_mouse_button(rsp_mouse_button),
      .rsp_mouse_is_release(rsp_mouse_is_release),
      .rsp_mouse_is_motion(rsp_mouse_is_motion),
      .rsp_mouse_modifiers(rsp_mouse_modifiers)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder state kept alongside the block
   tksp_pkg::mode_type      dec_mode = tksp_pkg::MODE_NORMAL;
   tksp_pkg::prefix_type    csi_pfx = tksp_pkg::PFX_NONE;
   int                      csi_len = 0;
   int                      csi_count = 0;
   bit                      csi_digit = 1'b0;
   bit                      csi_inter = 1'b0;
   logic [15:0]             csi_param [tksp_pkg::MAX_PARAMS];
   tksp_pkg::mouse_rec_type mouse_now = '0;

   logic [7:0]           tx_bytes [$];
   tksp_pkg::result_type pending_keys [$];
   int                   kind_hits [32];
   int                   total_bytes = 0;
   int                   accepted = 0;
   int                   checked = 0;
   int                   errors = 0;
   int                   cycles = 0;
   int                   tx_wait = 0;
   int                   rx_wait = 0;
   bit                   calm = 1'b0;
   tksp_pkg::result_type want, got;

   function automatic int pick_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic tksp_pkg::result_type decode_byte(input logic [7:0] c);
      tksp_pkg::result_type r;
      logic [4:0] kind;
      logic [7:0] bv;
      int acc, b, col, row, p;
      kind = tksp_pkg::KIND_UNKNOWN;
      bv = 8'h00;
      case (dec_mode)
         tksp_pkg::MODE_NORMAL: begin
            if (c == tksp_pkg::CH_ESC) begin
               dec_mode = tksp_pkg::MODE_ESC;
               kind = tksp_pkg::KIND_INCOMPLETE;
            end else if (c == tksp_pkg::CH_BS || c == tksp_pkg::CH_ERASE) begin
               kind = tksp_pkg::KIND_BS;
            end else begin
               kind = tksp_pkg::KIND_PLAIN;
               bv = c;
            end
         end
         tksp_pkg::MODE_ESC: begin
            if (c == tksp_pkg::CH_CSI_OPEN) begin
               dec_mode = tksp_pkg::MODE_CSI;
               csi_len = 0;
               csi_pfx = tksp_pkg::PFX_NONE;
               csi_count = 0;
               csi_digit = 1'b0;
               csi_inter = 1'b0;
               foreach (csi_param[i]) csi_param[i] = '0;
               kind = tksp_pkg::KIND_INCOMPLETE;
            end else if (c == tksp_pkg::CH_SS3_OPEN) begin
               dec_mode = tksp_pkg::MODE_APP;
               kind = tksp_pkg::KIND_INCOMPLETE;
            end else begin
               dec_mode = tksp_pkg::MODE_NORMAL;
               kind = tksp_pkg::KIND_ESCBYTE;
               bv = c;
            end
         end
         tksp_pkg::MODE_APP: begin
            dec_mode = tksp_pkg::MODE_NORMAL;
            if (c >= "A" && c <= "D") begin
               kind = tksp_pkg::KIND_UP + 5'(c - "A");
            end else if (c >= "P" && c <= "S") begin
               kind = tksp_pkg::KIND_F1 + 5'(c - "P");
            end else if (c >= "j" && c <= "y" && c != "w") begin
               // keypad digits and operators sit 0x40 above their characters
               kind = tksp_pkg::KIND_PLAIN;
               bv = c - tksp_pkg::KEYPAD_SHIFT;
            end else begin
               case (c)
                  "H": kind = tksp_pkg::KIND_HOME;
                  "F": kind = tksp_pkg::KIND_END;
                  "G": kind = tksp_pkg::KIND_PGDN;
                  "I": kind = tksp_pkg::KIND_PGUP;
                  "L": kind = tksp_pkg::KIND_INS;
                  "w": kind = tksp_pkg::KIND_DEL;
                  "M": kind = tksp_pkg::KIND_ENTER;
                  "X": begin
                     kind = tksp_pkg::KIND_PLAIN;
                     bv = "=";
                  end
                  default: kind = tksp_pkg::KIND_UNKNOWN;
               endcase
            end
         end
         default: begin
            if (c == tksp_pkg::CH_ESC) begin
               dec_mode = tksp_pkg::MODE_ESC;
               kind = tksp_pkg::KIND_INCOMPLETE;
            end else if (csi_len >= tksp_pkg::MAX_SEQ_LEN) begin
               dec_mode = tksp_pkg::MODE_NORMAL;
               kind = tksp_pkg::KIND_UNKNOWN;
            end else begin
               csi_len++;
               if (c < tksp_pkg::CTRL_LIMIT || c == tksp_pkg::CH_ERASE) begin
                  dec_mode = tksp_pkg::MODE_NORMAL;
                  if (c == tksp_pkg::CH_BS || c == tksp_pkg::CH_ERASE) begin
                     kind = tksp_pkg::KIND_BS;
                  end else begin
                     kind = tksp_pkg::KIND_PLAIN;
                     bv = c;
                  end
               end else if (c > tksp_pkg::FINAL_HI) begin
                  dec_mode = tksp_pkg::MODE_NORMAL;
                  kind = tksp_pkg::KIND_UNKNOWN;
               end else if (c >= tksp_pkg::PARAM_LO && c <= tksp_pkg::PARAM_HI) begin
                  kind = tksp_pkg::KIND_INCOMPLETE;
                  if (!csi_inter) begin
                     if (csi_len == 1 && (c == "<" || c == "?" || c == "=" || c == ">")) begin
                        csi_pfx = (c == "<") ? tksp_pkg::PFX_LT : tksp_pkg::PFX_OTHER;
                     end else if (c == ";" || c == ":") begin
                        if (csi_count < tksp_pkg::MAX_PARAMS) csi_count++;
                        csi_digit = 1'b0;
                     end else if (c >= "0" && c <= "9") begin
                        if (!csi_digit) begin
                           csi_digit = 1'b1;
                           if (csi_count == 0) csi_count = 1;
                        end
                        acc = int'(csi_param[csi_count-1]) * 10 + int'(c - "0");
                        csi_param[csi_count-1] = (acc > 65535) ? 16'hFFFF : 16'(acc);
                     end
                  end
               end else if (c >= tksp_pkg::INTER_LO && c <= tksp_pkg::INTER_HI) begin
                  csi_inter = 1'b1;
                  kind = tksp_pkg::KIND_INCOMPLETE;
               end else begin
                  dec_mode = tksp_pkg::MODE_NORMAL;
                  if (csi_pfx == tksp_pkg::PFX_LT && (c == "M" || c == "m")) begin
                     b = csi_param[0];
                     col = (csi_count > 1) ? int'(csi_param[1]) : 0;
                     row = (csi_count > 2) ? int'(csi_param[2]) : 0;
                     mouse_now.col = (col > 0) ? 16'(col - 1) : 16'd0;
                     mouse_now.row = (row > 0) ? 16'(row - 1) : 16'd0;
                     mouse_now.released = (c == "m");
                     mouse_now.moving = b[5];
                     mouse_now.modifiers = 3'((b >> 2) & 7);
                     if (b[6]) begin
                        mouse_now.button = b[0] ? tksp_pkg::BTN_WHEEL_DOWN
                                                : tksp_pkg::BTN_WHEEL_UP;
                     end else begin
                        mouse_now.button = 3'(b & 3);
                     end
                     kind = (c == "m") ? tksp_pkg::KIND_MRELEASE : tksp_pkg::KIND_MPRESS;
                  end else if (csi_pfx != tksp_pkg::PFX_NONE) begin
                     kind = tksp_pkg::KIND_UNKNOWN;
                  end else begin
                     case (c)
                        "A", "B", "C", "D": kind = tksp_pkg::KIND_UP + 5'(c - "A");
                        "H": kind = tksp_pkg::KIND_HOME;
                        "F": kind = tksp_pkg::KIND_END;
                        "G": kind = tksp_pkg::KIND_PGDN;
                        "I": kind = tksp_pkg::KIND_PGUP;
                        "L": kind = tksp_pkg::KIND_INS;
                        "Z": kind = tksp_pkg::KIND_STAB;
                        "~": begin
                           p = csi_param[0];
                           if (p == 1 || p == 7) kind = tksp_pkg::KIND_HOME;
                           else if (p == 2) kind = tksp_pkg::KIND_INS;
                           else if (p == 3) kind = tksp_pkg::KIND_DEL;
                           else if (p == 4 || p == 8) kind = tksp_pkg::KIND_END;
                           else if (p == 5) kind = tksp_pkg::KIND_PGUP;
                           else if (p == 6) kind = tksp_pkg::KIND_PGDN;
                           else if (p >= 11 && p <= 15)
                              kind = tksp_pkg::KIND_F1 + 5'(p - 11);
                           else if (p >= 17 && p <= 21)
                              kind = tksp_pkg::KIND_F6 + 5'(p - 17);
                           else if (p == 23 || p == 24)
                              kind = tksp_pkg::KIND_F11 + 5'(p - 23);
                           else kind = tksp_pkg::KIND_UNKNOWN;
                        end
                        default: kind = tksp_pkg::KIND_UNKNOWN;
                     endcase
                  end
               end
            end
         end
      endcase
      r.key_kind = kind;
      r.byte_value = bv;
      r.mouse = mouse_now;
      return r;
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) calm <= !calm;
   end

   // driver: predicts each byte as its transfer completes
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait <= 0;
         dec_mode = tksp_pkg::MODE_NORMAL;
         csi_len = 0;
         csi_pfx = tksp_pkg::PFX_NONE;
         csi_count = 0;
         csi_digit = 1'b0;
         csi_inter = 1'b0;
         foreach (csi_param[i]) csi_param[i] = '0;
         mouse_now = '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            want = decode_byte(req_byte_in);
            pending_keys.push_back(want);
            kind_hits[want.key_kind]++;
            accepted++;
         end
         if (tx_wait > 0) begin
            req_valid <= 1'b0;
            tx_wait <= tx_wait - 1;
         end else if (tx_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_byte_in <= tx_bytes.pop_front();
            tx_wait <= pick_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.key_kind = rsp_key_kind;
            got.byte_value = rsp_byte_value;
            got.mouse.col = rsp_mouse_col;
            got.mouse.row = rsp_mouse_row;
            got.mouse.button = rsp_mouse_button;
            got.mouse.released = rsp_mouse_is_release;
            got.mouse.moving = rsp_mouse_is_motion;
            got.mouse.modifiers = rsp_mouse_modifiers;
            if (pending_keys.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: kind %0d byte %h", got.key_kind, got.byte_value);
            end else begin
               want = pending_keys.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("result %0d expected: kind %0d byte %h col %0d row %0d",
                        checked, want.key_kind, want.byte_value, want.mouse.col,
                        want.mouse.row, " btn %0d rel %0d mot %0d mods %0d",
                        want.mouse.button, want.mouse.released, want.mouse.moving,
                        want.mouse.modifiers);
                     $display("result %0d actual:   kind %0d byte %h col %0d row %0d",
                        checked, got.key_kind, got.byte_value, got.mouse.col,
                        got.mouse.row, " btn %0d rel %0d mot %0d mods %0d",
                        got.mouse.button, got.mouse.released, got.mouse.moving,
                        got.mouse.modifiers);
                  end
               end
            end
            checked++;
            rx_wait = pick_wait();
         end
         if (rx_wait > 0) begin
            rsp_stall <= 1'b1;
            rx_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("terminal_key_sequence_parser_top verification failed");
         $finish;
      end
   end

   task automatic put_num(input int v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
   endtask

   function automatic int rnd_num();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $urandom_range(0, 30);
      if (sel < 9) return $urandom_range(0, 400);
      return $urandom_range(0, 99999);
   endfunction

   task automatic put_csi_open();
      tx_bytes.push_back(tksp_pkg::CH_ESC);
      tx_bytes.push_back(tksp_pkg::CH_CSI_OPEN);
   endtask

   initial begin
      string key_finals, app_keys, prefixes;
      int sel, n, len;
      key_finals = "ABCDHFGILZ~";
      app_keys = "ABCDPQRSHFGILMXwjklmnopqrstuvxy";
      prefixes = "<?=>";

      // directed opener: byte extremes, backspace/erase, ESC+byte, SS3 delete,
      // F12 by tilde code, SGR release with saturated column
      tx_bytes = '{8'h00, 8'hFF, tksp_pkg::CH_BS, tksp_pkg::CH_ERASE, tksp_pkg::CH_ESC, "x",
                   tksp_pkg::CH_ESC, tksp_pkg::CH_SS3_OPEN, "w"};
      put_csi_open();
      tx_bytes.push_back("2");
      tx_bytes.push_back("4");
      tx_bytes.push_back("~");
      put_csi_open();
      tx_bytes.push_back("<");
      put_num(65);
      tx_bytes.push_back(";");
      put_num(70000);
      tx_bytes.push_back(";");
      put_num(3);
      tx_bytes.push_back("m");

      while (tx_bytes.size() < RANDOM_BYTES + 28) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            tx_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (sel < 20) begin
            tx_bytes.push_back(tksp_pkg::CH_ESC);
            tx_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (sel < 35) begin
            tx_bytes.push_back(tksp_pkg::CH_ESC);
            tx_bytes.push_back(tksp_pkg::CH_SS3_OPEN);
            if ($urandom_range(0, 4) == 0) tx_bytes.push_back(8'($urandom_range(0, 255)));
            else tx_bytes.push_back(app_keys[$urandom_range(0, app_keys.len() - 1)]);
         end else if (sel < 60) begin
            put_csi_open();
            if ($urandom_range(0, 9) == 0) tx_bytes.push_back(prefixes[$urandom_range(0, 3)]);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0 || $urandom_range(0, 9) == 0)
                  tx_bytes.push_back(($urandom_range(0, 7) == 0) ? ":" : ";");
               if ($urandom_range(0, 1)) put_num($urandom_range(0, 25));
               else put_num(rnd_num());
            end
            if ($urandom_range(0, 5) == 0) tx_bytes.push_back(8'($urandom_range(8'h40, 8'h7E)));
            else tx_bytes.push_back(key_finals[$urandom_range(0, key_finals.len() - 1)]);
         end else if (sel < 82) begin
            // SGR mouse report, sometimes with missing or extra coordinates
            put_csi_open();
            tx_bytes.push_back("<");
            put_num($urandom_range(0, 127));
            n = $urandom_range(0, 9);
            if (n > 2) n = 2;
            else if (n == 2 && $urandom_range(0, 3) == 0) n = $urandom_range(3, 11);
            for (int i = 0; i < n; i++) begin
               tx_bytes.push_back(";");
               put_num(rnd_num());
            end
            tx_bytes.push_back($urandom_range(0, 1) ? "M" : "m");
         end else begin
            // broken or overlong CSI bodies
            put_csi_open();
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 80) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               sel = $urandom_range(0, 99);
               if (sel < 70) tx_bytes.push_back(8'($urandom_range(8'h30, 8'h3F)));
               else if (sel < 85) tx_bytes.push_back(8'($urandom_range(8'h20, 8'h2F)));
               else if (sel < 90) tx_bytes.push_back(prefixes[$urandom_range(0, 3)]);
               else if (sel < 93) tx_bytes.push_back(8'($urandom_range(0, 8'h1F)));
               else if (sel < 95) tx_bytes.push_back(tksp_pkg::CH_ERASE);
               else if (sel < 97) tx_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
               else tx_bytes.push_back(tksp_pkg::CH_ESC);
            end
            tx_bytes.push_back(8'($urandom_range(8'h40, 8'h7E)));
         end
      end
      total_bytes = tx_bytes.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_bytes || pending_keys.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      n = 0;
      foreach (kind_hits[k]) if (kind_hits[k] != 0) n++;
      $display("%0d bytes decoded, %0d results checked, %0d mismatches", total_bytes, checked,
         errors);
      $display("%0d of 31 key kinds seen, %0d mouse press and %0d mouse release events", n,
         kind_hits[tksp_pkg::KIND_MPRESS], kind_hits[tksp_pkg::KIND_MRELEASE]);
      if (errors == 0 && pending_keys.size() == 0) begin
         $display("terminal_key_sequence_parser_top verification clean");
      end else begin
         $display("terminal_key_sequence_parser_top verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/tksp_pkg.sv
hdl/tksp_param_file.sv
hdl/tksp_decoder.sv
hdl/terminal_key_sequence_parser_top.sv
test/testbench.sv
